FILE: src/omsrs_pkg.sv
// ----------------------------------------------------------------------------
// omsrs_pkg
// shared types and constants for the ordered multiset rank/select block
// ----------------------------------------------------------------------------
package omsrs_pkg;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_COUNT_BITS = 16;
    localparam int VALUE_BITS     = 31;
    localparam int TOTAL_BITS     = 24;

    localparam logic [VALUE_BITS-1:0] SENTINEL_POS = 31'sh3f3f3f3f;
    localparam logic [VALUE_BITS-1:0] SENTINEL_NEG = -31'sh3f3f3f3f;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX    = {TOTAL_BITS{1'b1}};

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_RANK   = 3'd2,
        ACT_KTH    = 3'd3,
        ACT_PRED   = 3'd4,
        ACT_SUCC   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_KRANGE = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAVE,
        S_DONE
    } state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        action_t                action;
        logic [VALUE_BITS-1:0]  operand;
        logic                   apply;
        logic                   hit;
        logic                   single;
    } cmd_t;

    // partial result handed from cell to cell
    typedef struct packed {
        logic [TOTAL_BITS-1:0]  acc;
        logic [VALUE_BITS-1:0]  ans;
        logic                   found;
        logic                   hit;
        logic                   sat;
        logic                   single;
    } carry_t;

endpackage

FILE: src/omsrs_cell.sv
// ----------------------------------------------------------------------------
// omsrs_cell
// one slot of the sorted chain: value, copy count and scan carry register
// ----------------------------------------------------------------------------
module omsrs_cell
    import omsrs_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic [VALUE_BITS-1:0]  left_value,
    input  logic [COUNT_BITS-1:0]  left_count,
    input  logic                   left_lt,
    input  logic [VALUE_BITS-1:0]  right_value,
    input  logic [COUNT_BITS-1:0]  right_count,
    input  carry_t                 carry_in,
    output carry_t                 carry_out,
    output logic [VALUE_BITS-1:0]  value,
    output logic [COUNT_BITS-1:0]  count,
    output logic                   lt
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    carry_t                carry_reg, carry_next;
    logic                  valid, eq, gt;
    logic [TOTAL_BITS-1:0] cnt_ext, cum;

    assign valid   = (count_reg != '0);
    assign lt      = valid && ($signed(value_reg) < $signed(cmd.operand));
    assign eq      = valid && (value_reg == cmd.operand);
    assign gt      = valid && ($signed(value_reg) > $signed(cmd.operand));
    assign cnt_ext = TOTAL_BITS'(count_reg);
    assign cum     = carry_in.acc + cnt_ext;

    always_comb
    begin
        carry_next        = carry_in;
        carry_next.hit    = carry_in.hit || eq;
        carry_next.sat    = carry_in.sat || (eq && count_reg == COUNT_MAX);
        carry_next.single = carry_in.single || (eq && count_reg == COUNT_ONE);
        case (cmd.action)
            ACT_RANK:
            begin
                if (lt)
                begin
                    carry_next.acc = cum;
                end
            end
            ACT_KTH:
            begin
                carry_next.acc = cum;
                if (!carry_in.found && valid
                    && cmd.operand[TOTAL_BITS-1:0] <= cum)
                begin
                    carry_next.found = 1'b1;
                    carry_next.ans   = value_reg;
                end
            end
            ACT_PRED:
            begin
                if (lt)
                begin
                    carry_next.ans = value_reg;
                end
            end
            ACT_SUCC:
            begin
                if (!carry_in.found && gt)
                begin
                    carry_next.found = 1'b1;
                    carry_next.ans   = value_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        if (cmd.apply)
        begin
            case (cmd.action)
                ACT_INSERT:
                begin
                    if (cmd.hit)
                    begin
                        if (eq)
                        begin
                            count_next = count_reg + COUNT_ONE;
                        end
                    end
                    else if (!lt)
                    begin
                        // open a slot: first cell at or above the operand takes it
                        if (left_lt)
                        begin
                            value_next = cmd.operand;
                            count_next = COUNT_ONE;
                        end
                        else
                        begin
                            value_next = left_value;
                            count_next = left_count;
                        end
                    end
                end
                ACT_REMOVE:
                begin
                    if (!cmd.single)
                    begin
                        if (eq)
                        begin
                            count_next = count_reg - COUNT_ONE;
                        end
                    end
                    else if (!lt)
                    begin
                        value_next = right_value;
                        count_next = right_count;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;
    assign value     = value_reg;
    assign count     = count_reg;

endmodule

FILE: src/ordered_multiset_rank_select.sv
// ----------------------------------------------------------------------------
// ordered_multiset_rank_select
// sorted multiset with copy counts kept in a chain of cells
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, action, operand       | item in
//  out     | out_valid, out_stall, answer, status      | item out
//
//  each item walks a scan carry along the chain one cell per cycle, then the
//  done state commits the update and loads the output register
//  the next item is taken while a finished result still waits on out_stall
//  reset clears all counts, so every cell starts empty
// ----------------------------------------------------------------------------
module ordered_multiset_rank_select
    import omsrs_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             action,
    input  logic signed [30:0]     operand,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [30:0]     answer,
    output logic [1:0]             status
);

    localparam int WCW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [WCW-1:0] WAVE_LAST = WCW'(CAPACITY - 1);

    state_t                state_reg, state_next;
    logic [WCW-1:0]        wave_reg, wave_next;
    action_t               action_reg;
    logic [VALUE_BITS-1:0] operand_reg;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] answer_reg, answer_next;
    status_t               status_reg, status_next;

    cmd_t                  cmd;
    carry_t                carry_init;
    carry_t                res;
    logic                  apply;
    logic                  kth_bad;

    logic [VALUE_BITS-1:0] cv [CAPACITY];
    logic [COUNT_BITS-1:0] cc [CAPACITY];
    logic                  clt [CAPACITY];
    carry_t                cy [CAPACITY+1];

    always_comb
    begin
        carry_init = '0;
        if (action_reg == ACT_PRED)
        begin
            carry_init.ans = SENTINEL_NEG;
        end
        else if (action_reg == ACT_SUCC)
        begin
            carry_init.ans = SENTINEL_POS;
        end
    end

    assign cy[0] = carry_init;
    assign res   = cy[CAPACITY];

    assign cmd.action  = action_reg;
    assign cmd.operand = operand_reg;
    assign cmd.apply   = apply;
    assign cmd.hit     = res.hit;
    assign cmd.single  = res.single;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VALUE_BITS-1:0] lv, rv;
            logic [COUNT_BITS-1:0] lc, rc;
            logic                  llt;
            if (g == 0)
            begin : g_first
                assign lv  = '0;
                assign lc  = '0;
                assign llt = 1'b1;
            end
            else
            begin : g_mid_l
                assign lv  = cv[g-1];
                assign lc  = cc[g-1];
                assign llt = clt[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign rv = '0;
                assign rc = '0;
            end
            else
            begin : g_mid_r
                assign rv = cv[g+1];
                assign rc = cc[g+1];
            end
            omsrs_cell #(
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_value  (lv),
                .left_count  (lc),
                .left_lt     (llt),
                .right_value (rv),
                .right_count (rc),
                .carry_in    (cy[g]),
                .carry_out   (cy[g+1]),
                .value       (cv[g]),
                .count       (cc[g]),
                .lt          (clt[g])
            );
        end
    endgenerate

    // k must lie in 1..total
    assign kth_bad = operand_reg[VALUE_BITS-1]
                     || (operand_reg == '0)
                     || (operand_reg[VALUE_BITS-2:TOTAL_BITS] != '0)
                     || (operand_reg[TOTAL_BITS-1:0] > total_reg);

    always_comb
    begin
        state_next     = state_reg;
        wave_next      = wave_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        answer_next    = answer_reg;
        status_next    = status_reg;
        apply          = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WAVE;
                    wave_next  = '0;
                end
            end
            S_WAVE:
            begin
                if (wave_reg == WAVE_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wave_next = wave_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    answer_next    = '0;
                    status_next    = ST_OK;
                    case (action_reg) inside
                        ACT_INSERT:
                        begin
                            if (total_reg == TOTAL_MAX || (res.hit && res.sat)
                                || (!res.hit && cc[CAPACITY-1] != '0))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                apply      = 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!res.hit)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                apply      = 1'b1;
                                total_next = total_reg - 1'b1;
                            end
                        end
                        ACT_RANK:
                        begin
                            answer_next = VALUE_BITS'(res.acc) + 1'b1;
                        end
                        ACT_KTH:
                        begin
                            if (kth_bad)
                            begin
                                status_next = ST_KRANGE;
                            end
                            else
                            begin
                                answer_next = res.ans;
                            end
                        end
                        ACT_PRED, ACT_SUCC:
                        begin
                            answer_next = res.ans;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wave_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wave_reg      <= wave_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            action_reg  <= action_t'(action);
            operand_reg <= operand;
        end
        answer_reg <= answer_next;
        status_reg <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

endmodule

FILE: sim/tb_ordered_multiset_rank_select.sv
// ----------------------------------------------------------------------------
// tb_ordered_multiset_rank_select
// self-checking bench for the ordered multiset: a behavioral copy of the
// store predicts every answer and status, and results are checked in order
// ----------------------------------------------------------------------------
module tb_ordered_multiset_rank_select;
    timeunit 1ns;
    timeprecision 1ps;
    import omsrs_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int COUNT_MAX  = (1 << DEF_COUNT_BITS) - 1;
    localparam int TOTAL_LIM  = (1 << TOTAL_BITS) - 1;
    localparam int ITEM_CYC   = CAP + 2;
    localparam int IDLE_LIMIT = 8000;
    localparam int HOLD_CYC   = 900;
    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;
    localparam logic signed [30:0] VAL_MAX = 31'sh3fffffff;
    localparam logic signed [30:0] VAL_MIN = -31'sh40000000;

    typedef struct {
        logic [2:0]         act;
        logic signed [30:0] opnd;
    } request_t;

    typedef struct {
        logic signed [30:0] ans;
        status_t            st;
    } reply_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] action;
    logic signed [30:0] operand;
    logic out_valid;
    logic out_stall;
    logic signed [30:0] answer;
    logic [1:0] status;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];

    // shadow copy of the sorted store, starts empty
    longint sh_value[CAP];
    int     sh_count[CAP];
    int     sh_used;
    int     sh_total;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_cnt;
    int errors;
    int idle_cycles;

    ordered_multiset_rank_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .operand   (operand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .answer    (answer),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic reply_t predict_multiset(input logic [2:0] act,
                                                input logic signed [30:0] opnd);
        reply_t r;
        longint x;
        longint k;
        longint below;
        int     p;
        int     q;
        bit     hit;
        x = longint'(opnd);
        r.ans = '0;
        r.st = ST_OK;
        p = 0;
        while (p < sh_used && sh_value[p] < x)
            p++;
        hit = (p < sh_used) && (sh_value[p] == x);
        case (act)
            ACT_INSERT:
            begin
                if (sh_total >= TOTAL_LIM)
                    r.st = ST_FULL;
                else if (hit)
                begin
                    if (sh_count[p] >= COUNT_MAX)
                        r.st = ST_FULL;
                    else
                    begin
                        sh_count[p]++;
                        sh_total++;
                    end
                end
                else if (sh_used >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    for (int i = sh_used; i > p; i--)
                    begin
                        sh_value[i] = sh_value[i-1];
                        sh_count[i] = sh_count[i-1];
                    end
                    sh_value[p] = x;
                    sh_count[p] = 1;
                    sh_used++;
                    sh_total++;
                end
            end
            ACT_REMOVE:
            begin
                if (!hit)
                    r.st = ST_ABSENT;
                else
                begin
                    sh_total--;
                    if (sh_count[p] > 1)
                        sh_count[p]--;
                    else
                    begin
                        for (int i = p; i + 1 < sh_used; i++)
                        begin
                            sh_value[i] = sh_value[i+1];
                            sh_count[i] = sh_count[i+1];
                        end
                        sh_used--;
                        sh_count[sh_used] = 0;
                    end
                end
            end
            ACT_RANK:
            begin
                below = 0;
                for (int i = 0; i < p; i++)
                    below += sh_count[i];
                r.ans = 31'(below + 1);
            end
            ACT_KTH:
            begin
                if (x < 1 || x > sh_total)
                    r.st = ST_KRANGE;
                else
                begin
                    k = x;
                    for (int i = 0; i < sh_used; i++)
                    begin
                        if (k <= sh_count[i])
                        begin
                            r.ans = 31'(sh_value[i]);
                            break;
                        end
                        k -= sh_count[i];
                    end
                end
            end
            ACT_PRED:
                r.ans = (p > 0) ? 31'(sh_value[p-1]) : SENTINEL_NEG;
            ACT_SUCC:
            begin
                q = hit ? p + 1 : p;
                r.ans = (q < sh_used) ? 31'(sh_value[q]) : SENTINEL_POS;
            end
            default:
                r.ans = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // driver: present the head of the pending queue, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= '0;
            operand  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_replies.push_back(predict_multiset(action, operand));
                void'(pending_reqs.pop_front());
            end
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                action   <= pending_reqs[0].act;
                operand  <= pending_reqs[0].opnd;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: random stall, long hold-off on request, in-order check
    always @(posedge clk or negedge rst_n)
    begin
        reply_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            hold_seen <= 0;
            hold_cnt  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    e = expected_replies.pop_front();
                    if (answer !== e.ans)
                        report_mismatch($sformatf("answer %0d, want %0d", answer, e.ans));
                    if (status !== e.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, e.st));
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen <= hold_reqs;
                hold_cnt  <= HOLD_CYC;
                out_stall <= 1'b1;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_item(input logic [2:0] act, input logic signed [30:0] opnd);
        request_t r;
        r.act = act;
        r.opnd = opnd;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_all();
        while (pending_reqs.size() > 0 || expected_replies.size() > 0)
            @(negedge clk);
    endtask

    task automatic random_items(input int n);
        int sel;
        logic signed [30:0] v;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                v = 31'($urandom);
            else if (sel < 12)
                v = (sel < 10) ? 31'(VAL_MAX - $urandom_range(3))
                               : 31'(VAL_MIN + $urandom_range(3));
            else
                v = 31'($signed($urandom_range(48)) - 24);
            sel = $urandom_range(99);
            if (sel < 30)
                queue_item(ACT_INSERT, v);
            else if (sel < 50)
                queue_item(ACT_REMOVE, v);
            else if (sel < 62)
                queue_item(ACT_RANK, v);
            else if (sel < 76)
                queue_item(ACT_KTH, (sel < 74) ? 31'($urandom_range(40)) : v);
            else if (sel < 87)
                queue_item(ACT_PRED, v);
            else if (sel < 98)
                queue_item(ACT_SUCC, v);
            else
                queue_item((sel == 98) ? ACT_BAD6 : ACT_BAD7, v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_reqs = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, extremes, duplicates, bad k, unknown actions
        queue_item(ACT_KTH, 31'sd1);
        queue_item(ACT_PRED, 31'sd0);
        queue_item(ACT_SUCC, 31'sd0);
        queue_item(ACT_RANK, 31'sd5);
        queue_item(ACT_REMOVE, 31'sd0);
        queue_item(ACT_INSERT, VAL_MAX);
        queue_item(ACT_INSERT, VAL_MIN);
        queue_item(ACT_INSERT, 31'sd0);
        queue_item(ACT_INSERT, 31'sd0);
        queue_item(ACT_KTH, 31'sd0);
        queue_item(ACT_KTH, -31'sd1);
        queue_item(ACT_KTH, 31'sd1);
        queue_item(ACT_KTH, 31'sd3);
        queue_item(ACT_KTH, 31'sd4);
        queue_item(ACT_KTH, 31'sd5);
        queue_item(ACT_KTH, VAL_MAX);
        queue_item(ACT_RANK, 31'sd0);
        queue_item(ACT_RANK, VAL_MAX);
        queue_item(ACT_PRED, VAL_MIN);
        queue_item(ACT_SUCC, VAL_MAX);
        queue_item(ACT_SUCC, 31'sd0);
        queue_item(ACT_REMOVE, 31'sd0);
        queue_item(ACT_REMOVE, 31'sd0);
        queue_item(ACT_BAD6, 31'sd7);
        queue_item(ACT_BAD7, -31'sd7);
        drain_all();

        // fill to capacity, then overflow with new distinct values
        send_idle_pct = 18;
        recv_stall_pct = 18;
        for (int i = 0; i < CAP + 2; i++)
            queue_item(ACT_INSERT, 31'($signed(i * 7 - 900)));
        queue_item(ACT_INSERT, 31'sd1);
        queue_item(ACT_INSERT, VAL_MAX);
        queue_item(ACT_RANK, 31'sd100);
        queue_item(ACT_KTH, 31'($urandom_range(CAP, 1)));
        for (int i = 0; i < 200; i++)
            queue_item(ACT_REMOVE, 31'($signed($urandom_range(CAP + 1) * 7 - 900)));
        drain_all();

        // random phases, receiver held off for a long stretch in the first
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs++;
        random_items(150);
        drain_all();
        send_idle_pct = 83;
        recv_stall_pct = 0;
        random_items(130);
        drain_all();
        send_idle_pct = 0;
        recv_stall_pct = 83;
        random_items(130);
        drain_all();
        send_idle_pct = 18;
        recv_stall_pct = 18;
        random_items(150);
        drain_all();

        repeat (2 * ITEM_CYC) @(negedge clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
src/omsrs_pkg.sv
src/omsrs_cell.sv
src/ordered_multiset_rank_select.sv
sim/tb_ordered_multiset_rank_select.sv
